// File: design/rta_pkg.sv
`timescale 1ns / 1ps

package rta_pkg;

    localparam int MAX_REGIONS = 64;
    localparam int ADDR_BITS   = 48;
    localparam int IDX_W       = $clog2(MAX_REGIONS);
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int KIND_W      = 4;
    localparam int MARGIN_W    = 21;
    localparam int WR_SLOTS    = 3;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(16'h4000);
    localparam logic [KIND_W-1:0]   TYPE_FREE    = KIND_W'(1);

    // request kinds
    localparam logic [1:0] KIND_ADD     = 2'd0;
    localparam logic [1:0] KIND_ALLOC   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    // result status codes
    localparam logic [2:0] STAT_DONE     = 3'd0;
    localparam logic [2:0] STAT_REJECT   = 3'd1;
    localparam logic [2:0] STAT_NOFIT    = 3'd2;
    localparam logic [2:0] STAT_FULL     = 3'd3;
    localparam logic [2:0] STAT_NOTFOUND = 3'd4;

    // configuration register indexes
    localparam logic CFG_TOTAL  = 1'b0;
    localparam logic CFG_MARGIN = 1'b1;

    typedef enum logic [1:0] {
        MODE_ADD,
        MODE_ALLOC,
        MODE_REL
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_RD_PREV,
        S_RD_CUR,
        S_RD_NEXT,
        S_DECIDE,
        S_SHIFT,
        S_WRITE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] lo_addr;
        logic [ADDR_BITS-1:0] hi_addr;
        logic [KIND_W-1:0]    rkind;
    } entry_t;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] idx;
        logic             we_lo;
        logic             we_hi;
        logic             we_kind;
        entry_t           data;
    } wr_slot_t;

    typedef struct packed {
        mode_t                       mode;
        logic [ADDR_BITS-1:0]        key;
        logic [CNT_W-1:0]            count;
        logic                        shift_up;
        logic                        shift_down;
        logic [CNT_W-1:0]            pos;
        wr_slot_t [WR_SLOTS-1:0]     wr;
        logic [CNT_W-1:0]            rd_idx;
    } cell_cmd_t;

    function automatic logic is_allocatable(input logic [KIND_W-1:0] k);
        return k inside {[KIND_W'(9):KIND_W'(14)]};
    endfunction

endpackage

// File: design/rta_cell.sv
`timescale 1ns / 1ps

module rta_cell
    import rta_pkg::*;
(
    input  logic             clk,
    input  logic [IDX_W-1:0] cell_idx,
    input  cell_cmd_t        cmd,
    input  entry_t           left_entry,
    input  entry_t           right_entry,
    output entry_t           entry,
    output logic             flag,
    output entry_t           rd_data
);

    entry_t               entry_reg;
    entry_t               entry_next;
    logic [CNT_W-1:0]     my_idx;
    logic                 in_use;
    logic [ADDR_BITS-1:0] len;

    assign my_idx = CNT_W'(cell_idx);
    assign in_use = my_idx < cmd.count;
    assign entry  = entry_reg;

    // measure the region, empty when the end is not above the start
    assign len = (entry_reg.hi_addr > entry_reg.lo_addr) ?
                 (entry_reg.hi_addr - entry_reg.lo_addr) : '0;

    // raise the search match for this entry
    always_comb
    begin
        case (cmd.mode)
            MODE_ADD:   flag = in_use && (cmd.key <= entry_reg.lo_addr);
            MODE_ALLOC: flag = in_use && (entry_reg.rkind == TYPE_FREE) && (len >= cmd.key);
            MODE_REL:   flag = in_use && (entry_reg.lo_addr == cmd.key);
            default:    flag = 1'b0;
        endcase
    end

    // drive the shared read bus when selected
    assign rd_data = (cmd.rd_idx == my_idx) ? entry_reg : '0;

    // shift along the chain, then apply field writes
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.shift_up && my_idx >= cmd.pos)
        begin
            entry_next = left_entry;
        end
        else if (cmd.shift_down && my_idx >= cmd.pos)
        begin
            entry_next = right_entry;
        end
        for (int k = 0; k < WR_SLOTS; k++)
        begin
            if (cmd.wr[k].valid && cmd.wr[k].idx == my_idx)
            begin
                if (cmd.wr[k].we_lo)
                begin
                    entry_next.lo_addr = cmd.wr[k].data.lo_addr;
                end
                if (cmd.wr[k].we_hi)
                begin
                    entry_next.hi_addr = cmd.wr[k].data.hi_addr;
                end
                if (cmd.wr[k].we_kind)
                begin
                    entry_next.rkind = cmd.wr[k].data.rkind;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// File: design/region_table_allocator.sv
`timescale 1ns / 1ps
// A request rejected on its fields goes straight to the done strobe without a scan; allocate runs the search twice.
// Throughput: one request at a time; busy stays high until the done strobe.
// The sequencer scans the cell row, reads three neighbors, then shifts the row one cell per cycle.
// Reset clears the entry count and registers (total_memory 0, split_margin 0x4000).
// Results are shown for one cycle on done; the receiver cannot stall.
module region_table_allocator
    import rta_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    input  logic [1:0]           kind,
    input  logic [ADDR_BITS-1:0] region_low,
    input  logic [ADDR_BITS-1:0] region_high,
    input  logic [KIND_W-1:0]    region_type,
    input  logic [ADDR_BITS-1:0] request_size,
    input  logic [ADDR_BITS-1:0] release_address,
    output logic [ADDR_BITS-1:0] granted_address,
    output logic [2:0]           status,
    output logic [CNT_W-1:0]     entry_count,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [ADDR_BITS-1:0] cfg_data
);

    state_t state_reg, state_next;

    logic [ADDR_BITS-1:0] total_reg;
    logic [MARGIN_W-1:0]  margin_reg;
    logic [CNT_W-1:0]     n_reg, n_next;

    mode_t                mode_reg, mode_next;
    logic                 alloc_reg, alloc_next;
    logic [ADDR_BITS-1:0] lo_reg, lo_next;
    logic [ADDR_BITS-1:0] hi_reg, hi_next;
    logic [KIND_W-1:0]    type_reg, type_next;
    logic [ADDR_BITS-1:0] key_reg, key_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 found_reg, found_next;
    logic [MAX_REGIONS-1:0] flags_reg, flags_next;
    entry_t               prev_reg, prev_next;
    entry_t               cur_reg, cur_next;
    entry_t               nxt_reg, nxt_next;
    logic                 up_reg, up_next;
    logic [1:0]           shcnt_reg, shcnt_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    wr_slot_t [WR_SLOTS-1:0] wr_reg, wr_next;
    logic [2:0]           status_reg, status_next;
    logic [ADDR_BITS-1:0] granted_reg, granted_next;

    cell_cmd_t            cmd;
    entry_t               cell_entry [MAX_REGIONS];
    entry_t               cell_rd [MAX_REGIONS];
    logic [MAX_REGIONS-1:0] cell_flag;
    entry_t               rd_bus;

    logic                 accept;
    logic                 early_reject;
    logic                 pick_found;
    logic [CNT_W-1:0]     pick_idx;

    // decision signals
    logic                 d_finish;
    logic                 d_to_scan;
    logic [2:0]           d_status;
    logic                 d_up;
    logic [1:0]           d_shcnt;
    logic [CNT_W-1:0]     d_n;
    wr_slot_t [WR_SLOTS-1:0] d_wr;
    logic [ADDR_BITS-1:0] d_lo;
    logic [ADDR_BITS-1:0] d_hi;

    logic [ADDR_BITS-1:0] cur_len;
    logic [ADDR_BITS-1:0] leftover;
    logic                 has_prev;
    logic                 has_next;
    logic                 room1;
    logic                 room2;
    logic                 pf;
    logic                 nf;
    logic [CNT_W:0]       n_wide;

    assign accept = start && (state_reg == S_IDLE);

    // cell row
    for (genvar g = 0; g < MAX_REGIONS; g++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;
        if (g == 0)
        begin : g_first
            assign left_e = cell_entry[0];
        end
        else
        begin : g_mid_l
            assign left_e = cell_entry[g-1];
        end
        if (g == MAX_REGIONS - 1)
        begin : g_last
            assign right_e = cell_entry[g];
        end
        else
        begin : g_mid_r
            assign right_e = cell_entry[g+1];
        end
        rta_cell u_cell (
            .clk         (clk),
            .cell_idx    (IDX_W'(g)),
            .cmd         (cmd),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry       (cell_entry[g]),
            .flag        (cell_flag[g]),
            .rd_data     (cell_rd[g])
        );
    end

    // merge the read bus
    always_comb
    begin
        rd_bus = '0;
        for (int j = 0; j < MAX_REGIONS; j++)
        begin
            rd_bus = rd_bus | cell_rd[j];
        end
    end

    // pick the first matching entry
    always_comb
    begin
        pick_found = 1'b0;
        pick_idx   = n_reg;
        for (int j = MAX_REGIONS - 1; j >= 0; j--)
        begin
            if (flags_reg[j])
            begin
                pick_found = 1'b1;
                pick_idx   = CNT_W'(j);
            end
        end
    end

    // check request fields on the start transfer
    always_comb
    begin
        case (kind)
            KIND_ADD:     early_reject = 1'b0;
            KIND_ALLOC:   early_reject = (request_size == '0) || (request_size > total_reg) ||
                                         !is_allocatable(region_type);
            KIND_RELEASE: early_reject = (release_address == '0) ||
                                         (release_address > total_reg);
            default:      early_reject = 1'b1;
        endcase
    end

    assign n_wide   = {1'b0, n_reg};
    assign room1    = (n_wide + (CNT_W+1)'(1)) <= (CNT_W+1)'(MAX_REGIONS);
    assign room2    = (n_wide + (CNT_W+1)'(2)) <= (CNT_W+1)'(MAX_REGIONS);
    assign has_prev = idx_reg != '0;
    assign has_next = (n_wide > ({1'b0, idx_reg} + (CNT_W+1)'(1)));
    assign pf       = has_prev && (prev_reg.rkind == TYPE_FREE);
    assign nf       = has_next && (nxt_reg.rkind == TYPE_FREE);
    assign cur_len  = (cur_reg.hi_addr > cur_reg.lo_addr) ?
                      (cur_reg.hi_addr - cur_reg.lo_addr) : '0;
    assign leftover = cur_len - key_reg;

    // decide the table update from the three neighbor entries
    always_comb
    begin
        d_finish  = 1'b0;
        d_to_scan = 1'b0;
        d_status  = STAT_DONE;
        d_up      = 1'b1;
        d_shcnt   = 2'd0;
        d_n       = n_reg;
        d_wr      = '0;
        d_lo      = lo_reg;
        d_hi      = hi_reg;
        case (mode_reg)
            MODE_ALLOC:
            begin
                if (!found_reg)
                begin
                    d_finish = 1'b1;
                    d_status = STAT_NOFIT;
                end
                else
                begin
                    d_to_scan = 1'b1;
                    d_lo      = cur_reg.lo_addr;
                    d_hi      = (leftover <= ADDR_BITS'(margin_reg)) ? cur_reg.hi_addr :
                                (cur_reg.lo_addr + key_reg);
                end
            end
            MODE_REL:
            begin
                if (!found_reg)
                begin
                    d_finish = 1'b1;
                    d_status = STAT_NOTFOUND;
                end
                else if (!is_allocatable(cur_reg.rkind))
                begin
                    d_finish = 1'b1;
                    d_status = STAT_REJECT;
                end
                else if (pf && nf)
                begin
                    d_up                  = 1'b0;
                    d_shcnt               = 2'd2;
                    d_n                   = n_reg - CNT_W'(2);
                    d_wr[0].valid         = 1'b1;
                    d_wr[0].idx           = idx_reg - CNT_W'(1);
                    d_wr[0].we_hi         = 1'b1;
                    d_wr[0].data.hi_addr  = nxt_reg.hi_addr;
                end
                else if (pf)
                begin
                    d_up                  = 1'b0;
                    d_shcnt               = 2'd1;
                    d_n                   = n_reg - CNT_W'(1);
                    d_wr[0].valid         = 1'b1;
                    d_wr[0].idx           = idx_reg - CNT_W'(1);
                    d_wr[0].we_hi         = 1'b1;
                    d_wr[0].data.hi_addr  = cur_reg.hi_addr;
                end
                else if (nf)
                begin
                    d_up                  = 1'b0;
                    d_shcnt               = 2'd1;
                    d_n                   = n_reg - CNT_W'(1);
                    d_wr[0].valid         = 1'b1;
                    d_wr[0].idx           = idx_reg;
                    d_wr[0].we_lo         = 1'b1;
                    d_wr[0].data.lo_addr  = cur_reg.lo_addr;
                end
                else
                begin
                    d_wr[0].valid         = 1'b1;
                    d_wr[0].idx           = idx_reg;
                    d_wr[0].we_kind       = 1'b1;
                    d_wr[0].data.rkind    = TYPE_FREE;
                end
            end
            default:
            begin
                // slot 0 puts the new entry at the insert point, or only sets its kind when the bounds match
                d_wr[0].valid        = 1'b1;
                d_wr[0].idx          = idx_reg;
                d_wr[0].we_lo        = 1'b1;
                d_wr[0].we_hi        = 1'b1;
                d_wr[0].we_kind      = 1'b1;
                d_wr[0].data.lo_addr = lo_reg;
                d_wr[0].data.hi_addr = hi_reg;
                d_wr[0].data.rkind   = type_reg;
                if (found_reg && lo_reg == cur_reg.lo_addr && hi_reg == cur_reg.hi_addr)
                begin
                    d_wr[0].we_lo = 1'b0;
                    d_wr[0].we_hi = 1'b0;
                end
                else if (found_reg && lo_reg == cur_reg.lo_addr)
                begin
                    d_shcnt              = 2'd1;
                    d_n                  = n_reg + CNT_W'(1);
                    d_wr[1].valid        = 1'b1;
                    d_wr[1].idx          = idx_reg + CNT_W'(1);
                    d_wr[1].we_lo        = 1'b1;
                    d_wr[1].data.lo_addr = hi_reg;
                    if (!room1)
                    begin
                        d_finish = 1'b1;
                        d_status = STAT_FULL;
                    end
                end
                else if (found_reg && has_prev && hi_reg == prev_reg.hi_addr)
                begin
                    d_shcnt              = 2'd1;
                    d_n                  = n_reg + CNT_W'(1);
                    d_wr[1].valid        = 1'b1;
                    d_wr[1].idx          = idx_reg - CNT_W'(1);
                    d_wr[1].we_hi        = 1'b1;
                    d_wr[1].data.hi_addr = lo_reg;
                    if (!room1)
                    begin
                        d_finish = 1'b1;
                        d_status = STAT_FULL;
                    end
                end
                else if (found_reg && pf)
                begin
                    d_shcnt              = 2'd2;
                    d_n                  = n_reg + CNT_W'(2);
                    d_wr[1].valid        = 1'b1;
                    d_wr[1].idx          = idx_reg - CNT_W'(1);
                    d_wr[1].we_hi        = 1'b1;
                    d_wr[1].data.hi_addr = lo_reg;
                    d_wr[2].valid        = 1'b1;
                    d_wr[2].idx          = idx_reg + CNT_W'(1);
                    d_wr[2].we_lo        = 1'b1;
                    d_wr[2].we_hi        = 1'b1;
                    d_wr[2].we_kind      = 1'b1;
                    d_wr[2].data.lo_addr = hi_reg;
                    d_wr[2].data.hi_addr = prev_reg.hi_addr;
                    d_wr[2].data.rkind   = TYPE_FREE;
                    if (!room2)
                    begin
                        d_finish = 1'b1;
                        d_status = STAT_FULL;
                    end
                end
                else
                begin
                    d_shcnt = 2'd1;
                    d_n     = n_reg + CNT_W'(1);
                    if (!room1)
                    begin
                        d_finish = 1'b1;
                        d_status = STAT_FULL;
                    end
                end
            end
        endcase
    end

    // advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = early_reject ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:    state_next = S_PICK;
            S_PICK:    state_next = S_RD_PREV;
            S_RD_PREV: state_next = S_RD_CUR;
            S_RD_CUR:  state_next = S_RD_NEXT;
            S_RD_NEXT: state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (d_finish)
                begin
                    state_next = S_DONE;
                end
                else if (d_to_scan)
                begin
                    state_next = S_SCAN;
                end
                else if (d_shcnt != 2'd0)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_SHIFT:   state_next = (shcnt_reg == 2'd1) ? S_WRITE : S_SHIFT;
            S_WRITE:   state_next = S_DONE;
            S_DONE:    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // update the datapath registers
    always_comb
    begin
        n_next       = n_reg;
        mode_next    = mode_reg;
        alloc_next   = alloc_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        type_next    = type_reg;
        key_next     = key_reg;
        idx_next     = idx_reg;
        found_next   = found_reg;
        flags_next   = flags_reg;
        prev_next    = prev_reg;
        cur_next     = cur_reg;
        nxt_next     = nxt_reg;
        up_next      = up_reg;
        shcnt_next   = shcnt_reg;
        pos_next     = pos_reg;
        wr_next      = wr_reg;
        status_next  = status_reg;
        granted_next = granted_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    lo_next      = region_low;
                    hi_next      = region_high;
                    type_next    = region_type;
                    alloc_next   = kind == KIND_ALLOC;
                    status_next  = STAT_REJECT;
                    granted_next = '0;
                    case (kind)
                        KIND_ALLOC:
                        begin
                            mode_next = MODE_ALLOC;
                            key_next  = request_size;
                        end
                        KIND_RELEASE:
                        begin
                            mode_next = MODE_REL;
                            key_next  = release_address;
                        end
                        default:
                        begin
                            mode_next = MODE_ADD;
                            key_next  = region_low;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                flags_next = cell_flag;
            end
            S_PICK:
            begin
                found_next = pick_found;
                idx_next   = pick_idx;
            end
            S_RD_PREV:
            begin
                prev_next = rd_bus;
            end
            S_RD_CUR:
            begin
                cur_next = rd_bus;
            end
            S_RD_NEXT:
            begin
                nxt_next = rd_bus;
            end
            S_DECIDE:
            begin
                status_next = d_status;
                if (d_to_scan)
                begin
                    mode_next = MODE_ADD;
                    lo_next   = d_lo;
                    hi_next   = d_hi;
                    key_next  = d_lo;
                end
                else
                begin
                    granted_next = (alloc_reg && !d_finish) ? lo_reg : '0;
                    if (!d_finish)
                    begin
                        up_next    = d_up;
                        shcnt_next = d_shcnt;
                        pos_next   = idx_reg;
                        wr_next    = d_wr;
                        n_next     = d_n;
                    end
                end
            end
            S_SHIFT:
            begin
                shcnt_next = shcnt_reg - 2'd1;
            end
            default:
            begin
            end
        endcase
    end

    // drive the cell row command
    always_comb
    begin
        cmd            = '0;
        cmd.mode       = mode_reg;
        cmd.key        = key_reg;
        cmd.count      = n_reg;
        cmd.pos        = pos_reg;
        cmd.rd_idx     = idx_reg;
        case (state_reg)
            S_RD_PREV: cmd.rd_idx     = idx_reg - CNT_W'(1);
            S_RD_NEXT: cmd.rd_idx     = idx_reg + CNT_W'(1);
            S_SHIFT:
            begin
                cmd.shift_up   = up_reg;
                cmd.shift_down = !up_reg;
            end
            S_WRITE:   cmd.wr         = wr_reg;
            default:
            begin
            end
        endcase
    end

    assign busy            = state_reg != S_IDLE;
    assign done            = state_reg == S_DONE;
    assign granted_address = granted_reg;
    assign status          = status_reg;
    assign entry_count     = n_reg;

    // hold configuration and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            n_reg      <= '0;
            total_reg  <= '0;
            margin_reg <= MARGIN_RESET;
            shcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            shcnt_reg <= shcnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TOTAL:  total_reg  <= cfg_data;
                    CFG_MARGIN: margin_reg <= cfg_data[MARGIN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // hold request payload and neighbor copies
    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        alloc_reg   <= alloc_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        type_reg    <= type_next;
        key_reg     <= key_next;
        idx_reg     <= idx_next;
        found_reg   <= found_next;
        flags_reg   <= flags_next;
        prev_reg    <= prev_next;
        cur_reg     <= cur_next;
        nxt_reg     <= nxt_next;
        up_reg      <= up_next;
        pos_reg     <= pos_next;
        wr_reg      <= wr_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
    end

endmodule
